// ----- src/coprocessor_dma_register_block_macros.svh -----
// Assertion macros shared by the coprocessor DMA register block RTL.
// Depends on nothing; included by the top level.
`ifndef COPROCESSOR_DMA_REGISTER_BLOCK_MACROS_SVH
`define COPROCESSOR_DMA_REGISTER_BLOCK_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define CDMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset
`define CDMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cdma_pkg.sv -----
// Shared types and constants of the coprocessor DMA register block.
// Depends on nothing; used by cdma_core and the top level.
`default_nettype none

package cdma_pkg;

    // Request commands
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    // Register indexes
    localparam logic [2:0] REG_LOCAL_ADDR = 3'd0;
    localparam logic [2:0] REG_RAM_ADDR   = 3'd1;
    localparam logic [2:0] REG_RD_LEN     = 3'd2;
    localparam logic [2:0] REG_WR_LEN     = 3'd3;
    localparam logic [2:0] REG_STATUS     = 3'd4;
    localparam logic [2:0] REG_FULL       = 3'd5;
    localparam logic [2:0] REG_BUSY       = 3'd6;
    localparam logic [2:0] REG_SEMAPHORE  = 3'd7;

    // Address and length masks
    localparam logic [12:0] LOCAL_ADDR_MASK = 13'h1FF8;
    localparam logic [23:0] RAM_ADDR_MASK   = 24'hFFFFF8;
    localparam logic [31:0] LENGTH_MASK     = ~32'h0070_0007;
    localparam logic [11:0] BLOCK_MASK      = 12'hFF8;
    localparam logic [11:0] ROW_LOW_BITS    = 12'h007;

    // Status bit positions
    localparam int unsigned ST_BUSY = 2;
    localparam int unsigned ST_FULL = 3;

    typedef struct packed {
        cmd_t        command;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        xfer_valid;
        logic [23:0] xfer_ram_addr;
        logic [11:0] xfer_local_addr;
        logic        xfer_instr_bank;
        logic        xfer_to_ram;
        logic        intr_raise;
        logic        intr_clear;
    } result_t;

    // Engine flags seen by the top level
    typedef struct packed {
        logic busy;
        logic full;
        logic st_busy;
        logic st_full;
    } flags_t;

endpackage

`default_nettype wire

// ----- src/cdma_core.sv -----
// Register file and strided DMA sequencer: turns one request into one result
// and updates all engine state. Depends on cdma_pkg.
`default_nettype none

module cdma_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire cdma_pkg::item_t  item,
    output cdma_pkg::result_t     result,
    output cdma_pkg::flags_t      flags
);

    logic [12:0] active_local_reg, active_local_next;
    logic [23:0] active_ram_reg, active_ram_next;
    logic [31:0] rd_len_reg, rd_len_next;
    logic [31:0] wr_len_reg, wr_len_next;
    logic [14:0] status_reg, status_next;
    logic        full_reg, full_next;
    logic        busy_reg, busy_next;
    logic        sema_reg, sema_next;
    logic [12:0] pend_local_reg, pend_local_next;
    logic [23:0] pend_ram_reg, pend_ram_next;
    logic [31:0] pend_len_reg, pend_len_next;
    logic        pend_to_ram_reg, pend_to_ram_next;
    logic        active_to_ram_reg, active_to_ram_next;
    logic [12:0] bytes_left_reg, bytes_left_next;
    logic [11:0] row_len_reg, row_len_next;
    logic [8:0]  rows_left_reg, rows_left_next;
    logic [11:0] row_skip_reg, row_skip_next;
    logic [23:0] cursor_ram_reg, cursor_ram_next;
    logic [11:0] cursor_local_reg, cursor_local_next;
    logic        do_load;
    logic        do_end;
    logic [12:0] bytes_m1;

    // One set/clear pair: both or neither leaves the bit alone
    function automatic logic pair_bit(input logic cur, input logic set, input logic clr);
        logic b;
        b = cur;
        if (set && !clr) b = 1'b1;
        if (clr && !set) b = 1'b0;
        return b;
    endfunction

    // Status register write; busy and full bits are read only
    function automatic logic [14:0] status_write(input logic [14:0] cur,
                                                 input logic [31:0] v);
        logic [14:0] s;
        s = cur;
        for (int i = 0; i < 8; i++) begin
            s[7 + i] = pair_bit(cur[7 + i], v[10 + 2 * i], v[9 + 2 * i]);
        end
        s[6] = pair_bit(cur[6], v[8], v[7]);
        s[5] = pair_bit(cur[5], v[6], v[5]);
        if (v[2]) s[1] = 1'b0;
        s[0] = pair_bit(cur[0], v[1], v[0]);
        return s;
    endfunction

    // Next state and result for the request in flight
    always_comb
    begin
        active_local_next  = active_local_reg;
        active_ram_next    = active_ram_reg;
        rd_len_next        = rd_len_reg;
        wr_len_next        = wr_len_reg;
        status_next        = status_reg;
        full_next          = full_reg;
        busy_next          = busy_reg;
        sema_next          = sema_reg;
        pend_local_next    = pend_local_reg;
        pend_ram_next      = pend_ram_reg;
        pend_len_next      = pend_len_reg;
        pend_to_ram_next   = pend_to_ram_reg;
        active_to_ram_next = active_to_ram_reg;
        bytes_left_next    = bytes_left_reg;
        row_len_next       = row_len_reg;
        rows_left_next     = rows_left_reg;
        row_skip_next      = row_skip_reg;
        cursor_ram_next    = cursor_ram_reg;
        cursor_local_next  = cursor_local_reg;
        result             = '0;
        do_load            = 1'b0;
        do_end             = 1'b0;
        bytes_m1           = 13'd0;

        if (fire) begin
            case (item.command)
                cdma_pkg::CMD_WRITE:
                begin
                    case (item.reg_index)
                        cdma_pkg::REG_LOCAL_ADDR:
                            pend_local_next = item.write_data[12:0] & cdma_pkg::LOCAL_ADDR_MASK;
                        cdma_pkg::REG_RAM_ADDR:
                            pend_ram_next = item.write_data[23:0] & cdma_pkg::RAM_ADDR_MASK;
                        cdma_pkg::REG_RD_LEN, cdma_pkg::REG_WR_LEN:
                        begin
                            // queue the transfer unless one is already waiting
                            if (!full_reg) begin
                                pend_len_next    = item.write_data & cdma_pkg::LENGTH_MASK;
                                pend_to_ram_next = (item.reg_index == cdma_pkg::REG_WR_LEN);
                                if (busy_reg) begin
                                    full_next                     = 1'b1;
                                    status_next[cdma_pkg::ST_FULL] = 1'b1;
                                end
                            end
                            if (!busy_reg) do_load = 1'b1;
                        end
                        cdma_pkg::REG_STATUS:
                        begin
                            status_next       = status_write(status_reg, item.write_data);
                            result.intr_raise = item.write_data[4];
                            result.intr_clear = item.write_data[3];
                        end
                        cdma_pkg::REG_SEMAPHORE:
                            sema_next = item.write_data[0];
                        default: ;
                    endcase
                end
                cdma_pkg::CMD_READ:
                begin
                    case (item.reg_index)
                        cdma_pkg::REG_LOCAL_ADDR: result.read_data = {19'd0, active_local_reg};
                        cdma_pkg::REG_RAM_ADDR:   result.read_data = {8'd0, active_ram_reg};
                        cdma_pkg::REG_RD_LEN:     result.read_data = rd_len_reg;
                        cdma_pkg::REG_WR_LEN:     result.read_data = wr_len_reg;
                        cdma_pkg::REG_STATUS:     result.read_data = {17'd0, status_reg};
                        cdma_pkg::REG_FULL:       result.read_data = {31'd0, full_reg};
                        cdma_pkg::REG_BUSY:       result.read_data = {31'd0, busy_reg};
                        default:                  result.read_data = {31'd0, sema_reg};
                    endcase
                end
                cdma_pkg::CMD_TICK:
                begin
                    if (busy_reg) begin
                        if (rows_left_reg == 9'd0) begin
                            do_end = 1'b1;
                        end else if (bytes_left_reg != 13'd0) begin
                            // issue one 8-byte block
                            result.xfer_valid      = 1'b1;
                            result.xfer_ram_addr   = cursor_ram_reg;
                            result.xfer_local_addr = cursor_local_reg;
                            result.xfer_instr_bank = active_local_reg[12];
                            result.xfer_to_ram     = active_to_ram_reg;
                            bytes_left_next   = bytes_left_reg - 13'd8;
                            cursor_ram_next   = cursor_ram_reg + 24'd8;
                            cursor_local_next = cursor_local_reg + 12'd8;
                            bytes_m1          = bytes_left_next - 13'd1;
                            rd_len_next = {row_skip_reg, 20'd0}
                                        | {11'd0, rows_left_reg, 12'd0}
                                        | {20'd0, bytes_m1[11:3], 3'd0};
                            wr_len_next = rd_len_next;
                        end else begin
                            // row end: step over the skip, rearm the row
                            rows_left_next  = rows_left_reg - 9'd1;
                            bytes_left_next = {1'b0, row_len_reg} + 13'd1;
                            cursor_ram_next = cursor_ram_reg + {12'd0, row_skip_reg};
                            if (rows_left_next == 9'd0) do_end = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // Finish: start the queued transfer or go idle
        if (do_end) begin
            if (full_reg) begin
                do_load                        = 1'b1;
                full_next                      = 1'b0;
                status_next[cdma_pkg::ST_FULL] = 1'b0;
            end else begin
                busy_next                      = 1'b0;
                status_next[cdma_pkg::ST_BUSY] = 1'b0;
            end
        end

        // Start: pending becomes active, cursors and row counters load
        if (do_load) begin
            active_local_next  = pend_local_next;
            active_ram_next    = pend_ram_next;
            rd_len_next        = pend_len_next;
            wr_len_next        = pend_len_next;
            active_to_ram_next = pend_to_ram_next;
            busy_next          = 1'b1;
            status_next[cdma_pkg::ST_BUSY] = 1'b1;
            cursor_ram_next    = pend_ram_next & cdma_pkg::RAM_ADDR_MASK;
            cursor_local_next  = pend_local_next[11:0] & cdma_pkg::BLOCK_MASK;
            row_len_next       = pend_len_next[11:0] | cdma_pkg::ROW_LOW_BITS;
            bytes_left_next    = {1'b0, row_len_next} + 13'd1;
            rows_left_next     = {1'b0, pend_len_next[19:12]} + 9'd1;
            row_skip_next      = pend_len_next[31:20] & cdma_pkg::BLOCK_MASK;
        end
    end

    // Engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_local_reg  <= '0;
            active_ram_reg    <= '0;
            rd_len_reg        <= '0;
            wr_len_reg        <= '0;
            status_reg        <= '0;
            full_reg          <= 1'b0;
            busy_reg          <= 1'b0;
            sema_reg          <= 1'b0;
            pend_local_reg    <= '0;
            pend_ram_reg      <= '0;
            pend_len_reg      <= '0;
            pend_to_ram_reg   <= 1'b0;
            active_to_ram_reg <= 1'b0;
            bytes_left_reg    <= '0;
            row_len_reg       <= '0;
            rows_left_reg     <= '0;
            row_skip_reg      <= '0;
            cursor_ram_reg    <= '0;
            cursor_local_reg  <= '0;
        end else begin
            active_local_reg  <= active_local_next;
            active_ram_reg    <= active_ram_next;
            rd_len_reg        <= rd_len_next;
            wr_len_reg        <= wr_len_next;
            status_reg        <= status_next;
            full_reg          <= full_next;
            busy_reg          <= busy_next;
            sema_reg          <= sema_next;
            pend_local_reg    <= pend_local_next;
            pend_ram_reg      <= pend_ram_next;
            pend_len_reg      <= pend_len_next;
            pend_to_ram_reg   <= pend_to_ram_next;
            active_to_ram_reg <= active_to_ram_next;
            bytes_left_reg    <= bytes_left_next;
            row_len_reg       <= row_len_next;
            rows_left_reg     <= rows_left_next;
            row_skip_reg      <= row_skip_next;
            cursor_ram_reg    <= cursor_ram_next;
            cursor_local_reg  <= cursor_local_next;
        end
    end

    assign flags.busy    = busy_reg;
    assign flags.full    = full_reg;
    assign flags.st_busy = status_reg[cdma_pkg::ST_BUSY];
    assign flags.st_full = status_reg[cdma_pkg::ST_FULL];

endmodule

`default_nettype wire

// ----- src/coprocessor_dma_register_block.sv -----
// Top level of the coprocessor DMA register block: request register, result
// register and handshake. Depends on cdma_pkg, cdma_core and the macro header.
`default_nettype none

`include "coprocessor_dma_register_block_macros.svh"

// Takes one request (register write, register read or DMA tick) per clock and
// returns exactly one result per request, in order. A request is captured in
// the request register, handled in a single pass by the register file and DMA
// sequencer, and its result held in the result register; throughput is one request
// per cycle while the result side keeps up. All state lives in flip-flops; the
// local and RAM memories are outside and are driven from the xfer_* fields, at
// most one 8-byte block per busy tick.
module coprocessor_dma_register_block (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire logic [1:0]  command,
    input  wire logic [2:0]  reg_index,
    input  wire logic [31:0] write_data,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [31:0]      read_data,
    output logic             xfer_valid,
    output logic [23:0]      xfer_ram_addr,
    output logic [11:0]      xfer_local_addr,
    output logic             xfer_instr_bank,
    output logic             xfer_to_ram,
    output logic             intr_raise,
    output logic             intr_clear
);

    logic               stage_valid_reg, stage_valid_next;
    cdma_pkg::item_t    stage_reg;
    logic               res_valid_reg, res_valid_next;
    cdma_pkg::result_t  res_reg;
    cdma_pkg::result_t  core_result;
    cdma_pkg::flags_t   flags;
    logic               out_free;
    logic               stage_fire;
    logic               cmd_fire;
    logic               flags_agree;
    logic               res_no_xfer;
    logic               xfer_zero;
    logic               idle_tick;

    // Handshake: result register frees when empty or being taken
    assign out_free   = !res_valid_reg || !res_stall;
    assign stage_fire = stage_valid_reg && out_free;
    assign cmd_stall  = stage_valid_reg && !out_free;
    assign cmd_fire   = cmd_valid && !cmd_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (cmd_fire) stage_valid_next = 1'b1;
        else if (stage_fire) stage_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (stage_fire) res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall) res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire) begin
            stage_reg.command    <= cdma_pkg::cmd_t'(command);
            stage_reg.reg_index  <= reg_index;
            stage_reg.write_data <= write_data;
        end
        if (stage_fire) begin
            res_reg <= core_result;
        end
    end

    cdma_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (stage_fire),
        .item   (stage_reg),
        .result (core_result),
        .flags  (flags)
    );

    assign res_valid       = res_valid_reg;
    assign read_data       = res_reg.read_data;
    assign xfer_valid      = res_reg.xfer_valid;
    assign xfer_ram_addr   = res_reg.xfer_ram_addr;
    assign xfer_local_addr = res_reg.xfer_local_addr;
    assign xfer_instr_bank = res_reg.xfer_instr_bank;
    assign xfer_to_ram     = res_reg.xfer_to_ram;
    assign intr_raise      = res_reg.intr_raise;
    assign intr_clear      = res_reg.intr_clear;

    // Terms for the checks
    assign flags_agree = (flags.st_busy == flags.busy) && (flags.st_full == flags.full);
    assign res_no_xfer = res_valid_reg && !res_reg.xfer_valid;
    assign xfer_zero   = (res_reg.xfer_ram_addr == 24'd0) && (res_reg.xfer_local_addr == 12'd0)
                         && !res_reg.xfer_instr_bank && !res_reg.xfer_to_ram;
    assign idle_tick   = stage_fire && !flags.busy
                         && (stage_reg.command == cdma_pkg::CMD_TICK);

    // Checks
    `CDMA_ASSERT_NOW(a_full_needs_busy, clk, rst_n, flags.full, flags.busy, "full while idle")
    `CDMA_ASSERT_NOW(a_status_mirror, clk, rst_n, 1'b1, flags_agree, "status flags disagree")
    `CDMA_ASSERT_NOW(a_idle_fields_zero, clk, rst_n, res_no_xfer, xfer_zero, "stray xfer fields")
    `CDMA_ASSERT_NEXT(a_idle_tick_no_xfer, clk, rst_n, idle_tick, res_no_xfer, "xfer on idle tick")

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the coprocessor DMA register block.
// Depends on cdma_pkg and coprocessor_dma_register_block; register accesses
// and DMA ticks are checked against an in-bench model of the register file.
`default_nettype none

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_REQS = 750;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic [1:0]  command = '0;
    logic [2:0]  reg_index = '0;
    logic [31:0] write_data = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [31:0] read_data;
    logic        xfer_valid;
    logic [23:0] xfer_ram_addr;
    logic [11:0] xfer_local_addr;
    logic        xfer_instr_bank;
    logic        xfer_to_ram;
    logic        intr_raise;
    logic        intr_clear;

    coprocessor_dma_register_block i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .command         (command),
        .reg_index       (reg_index),
        .write_data      (write_data),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .read_data       (read_data),
        .xfer_valid      (xfer_valid),
        .xfer_ram_addr   (xfer_ram_addr),
        .xfer_local_addr (xfer_local_addr),
        .xfer_instr_bank (xfer_instr_bank),
        .xfer_to_ram     (xfer_to_ram),
        .intr_raise      (intr_raise),
        .intr_clear      (intr_clear)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cdma_pkg::item_t   request_queue[$];
    cdma_pkg::result_t expected_results[$];
    cdma_pkg::item_t   driven_req;
    int unsigned planned_count = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned hold_left = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    // Model state: queued transfer, active registers and row sequencer
    logic [12:0] pend_local = '0, act_local = '0;
    logic [23:0] pend_ram = '0, act_ram = '0;
    logic [31:0] pend_len = '0, rd_len = '0, wr_len = '0;
    logic [14:0] status = '0;
    logic        full_flag = 1'b0, busy_flag = 1'b0, sem_flag = 1'b0;
    logic        pend_to_ram = 1'b0, act_to_ram = 1'b0;
    logic [12:0] row_bytes = '0;
    logic [11:0] row_span = '0;
    logic [8:0]  row_count = '0;
    logic [11:0] stride = '0;
    logic [23:0] ram_ptr = '0;
    logic [11:0] local_ptr = '0;

    // Mostly no gap, some short ones, a few long ones
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic pair_update(logic cur, logic set_b, logic clr_b);
        if (set_b && !clr_b)
            return 1'b1;
        if (clr_b && !set_b)
            return 1'b0;
        return cur;
    endfunction

    // Row geometry from the length register of the new transfer
    task automatic setup_rows();
        ram_ptr   = act_ram & cdma_pkg::RAM_ADDR_MASK;
        local_ptr = act_local[11:0] & cdma_pkg::BLOCK_MASK;
        row_span  = rd_len[11:0] | cdma_pkg::ROW_LOW_BITS;
        row_bytes = {1'b0, row_span} + 13'd1;
        row_count = {1'b0, rd_len[19:12]} + 9'd1;
        stride    = rd_len[31:20] & cdma_pkg::BLOCK_MASK;
    endtask

    task automatic launch_queued();
        act_local       = pend_local;
        act_ram         = pend_ram;
        rd_len          = pend_len;
        wr_len          = pend_len;
        act_to_ram      = pend_to_ram;
        busy_flag       = 1'b1;
        status[cdma_pkg::ST_BUSY] = 1'b1;
        setup_rows();
    endtask

    task automatic close_transfer();
        if (full_flag)
        begin
            launch_queued();
            full_flag       = 1'b0;
            status[cdma_pkg::ST_FULL] = 1'b0;
        end
        else
        begin
            busy_flag       = 1'b0;
            status[cdma_pkg::ST_BUSY] = 1'b0;
        end
    endtask

    // Advance the model by one request and return its result
    task automatic dma_predict(input cdma_pkg::item_t rq, output cdma_pkg::result_t res);
        logic [31:0] v;
        logic [31:0] len_word;
        int          i;
        v   = rq.write_data;
        res = '0;
        case (rq.command)
            cdma_pkg::CMD_WRITE:
                case (rq.reg_index)
                    cdma_pkg::REG_LOCAL_ADDR: pend_local = v[12:0] & cdma_pkg::LOCAL_ADDR_MASK;
                    cdma_pkg::REG_RAM_ADDR:   pend_ram = v[23:0] & cdma_pkg::RAM_ADDR_MASK;
                    cdma_pkg::REG_RD_LEN, cdma_pkg::REG_WR_LEN:
                    begin
                        // a length write while full leaves the queued transfer alone
                        if (!full_flag)
                        begin
                            pend_len    = v & cdma_pkg::LENGTH_MASK;
                            pend_to_ram = (rq.reg_index == cdma_pkg::REG_WR_LEN);
                            if (busy_flag)
                            begin
                                full_flag       = 1'b1;
                                status[cdma_pkg::ST_FULL] = 1'b1;
                            end
                        end
                        if (!busy_flag)
                            launch_queued();
                    end
                    cdma_pkg::REG_STATUS:
                    begin
                        for (i = 0; i < 8; i++)
                            status[7 + i] = pair_update(status[7 + i], v[10 + 2 * i],
                                                        v[9 + 2 * i]);
                        status[6] = pair_update(status[6], v[8], v[7]);
                        status[5] = pair_update(status[5], v[6], v[5]);
                        res.intr_raise = v[4];
                        res.intr_clear = v[3];
                        if (v[2])
                            status[1] = 1'b0;
                        status[0] = pair_update(status[0], v[1], v[0]);
                    end
                    cdma_pkg::REG_SEMAPHORE:  sem_flag = v[0];
                    default:        ;
                endcase
            cdma_pkg::CMD_READ:
                case (rq.reg_index)
                    cdma_pkg::REG_LOCAL_ADDR: res.read_data = 32'(act_local);
                    cdma_pkg::REG_RAM_ADDR:   res.read_data = 32'(act_ram);
                    cdma_pkg::REG_RD_LEN:     res.read_data = rd_len;
                    cdma_pkg::REG_WR_LEN:     res.read_data = wr_len;
                    cdma_pkg::REG_STATUS:     res.read_data = 32'(status);
                    cdma_pkg::REG_FULL:       res.read_data = 32'(full_flag);
                    cdma_pkg::REG_BUSY:       res.read_data = 32'(busy_flag);
                    default:                  res.read_data = 32'(sem_flag);
                endcase
            cdma_pkg::CMD_TICK:
                if (busy_flag)
                begin
                    if (row_count == '0)
                        close_transfer();
                    else if (row_bytes != '0)
                    begin
                        // one 8-byte block, length registers track the remainder
                        res.xfer_valid      = 1'b1;
                        res.xfer_ram_addr   = ram_ptr;
                        res.xfer_local_addr = local_ptr;
                        res.xfer_instr_bank = act_local[12];
                        res.xfer_to_ram     = act_to_ram;
                        row_bytes = row_bytes - 13'd8;
                        ram_ptr   = ram_ptr + 24'd8;
                        local_ptr = local_ptr + 12'd8;
                        len_word  = (32'(stride) << 20) | (32'(row_count) << 12) |
                                    (32'(row_bytes - 13'd1) & 32'(cdma_pkg::BLOCK_MASK));
                        rd_len = len_word;
                        wr_len = len_word;
                    end
                    else
                    begin
                        // row end: apply skip, finish only when no rows remain
                        row_count = row_count - 9'd1;
                        row_bytes = {1'b0, row_span} + 13'd1;
                        ram_ptr   = ram_ptr + 24'(stride);
                        if (row_count == '0)
                            close_transfer();
                    end
                end
            default: ;
        endcase
    endtask

    task automatic queue_request(input cdma_pkg::cmd_t c, input logic [2:0] idx,
                                 input logic [31:0] data);
        cdma_pkg::item_t rq;
        rq.command    = c;
        rq.reg_index  = idx;
        rq.write_data = data;
        request_queue.push_back(rq);
        planned_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        cdma_pkg::item_t   next_req;
        cdma_pkg::result_t predicted;
        if (!rst_n)
        begin
            cmd_valid  <= 1'b0;
            command    <= cdma_pkg::CMD_WRITE;
            reg_index  <= '0;
            write_data <= '0;
        end
        else if (!(cmd_valid && cmd_stall))
        begin
            if (cmd_valid)
            begin
                dma_predict(driven_req, predicted);
                expected_results.push_back(predicted);
                if ($urandom_range(0, 79) == 0)
                    send_calm = !send_calm;
            end
            if (send_gap > 0)
            begin
                send_gap--;
                cmd_valid <= 1'b0;
            end
            else if (request_queue.size() > 0)
            begin
                next_req   = request_queue.pop_front();
                driven_req = next_req;
                command    <= next_req.command;
                reg_index  <= next_req.reg_index;
                write_data <= next_req.write_data;
                cmd_valid  <= 1'b1;
                send_gap   = pick_gap(send_calm);
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // Result monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        cdma_pkg::result_t want;
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: read_data %h xfer_valid %b", $time,
                             read_data, xfer_valid);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("xfer_valid", 32'(want.xfer_valid), 32'(xfer_valid));
                    check_field("xfer_ram_addr", 32'(want.xfer_ram_addr), 32'(xfer_ram_addr));
                    check_field("xfer_local_addr", 32'(want.xfer_local_addr),
                                32'(xfer_local_addr));
                    check_field("xfer_instr_bank", 32'(want.xfer_instr_bank),
                                32'(xfer_instr_bank));
                    check_field("xfer_to_ram", 32'(want.xfer_to_ram), 32'(xfer_to_ram));
                    check_field("intr_raise", 32'(want.intr_raise), 32'(intr_raise));
                    check_field("intr_clear", 32'(want.intr_clear), 32'(intr_clear));
                end
                if ($urandom_range(0, 79) == 0)
                    recv_calm = !recv_calm;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
                hold_left = pick_gap(recv_calm);
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int unsigned pick;
        int unsigned n;
        logic [31:0] len_word;

        // Directed: idle tick, status pairs, ignored registers, address extremes
        queue_request(cdma_pkg::CMD_TICK, cdma_pkg::REG_LOCAL_ADDR, 32'hFFFF_FFFF);
        queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_STATUS, 32'hFFFF_FFFF);
        queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_STATUS, 32'h0155_5552);
        queue_request(cdma_pkg::CMD_READ, cdma_pkg::REG_STATUS, 32'h0);
        queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_STATUS, 32'h00AA_AAAD);
        queue_request(cdma_pkg::CMD_READ, cdma_pkg::REG_STATUS, 32'h0);
        queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_SEMAPHORE, 32'hFFFF_FFFF);
        queue_request(cdma_pkg::CMD_READ, cdma_pkg::REG_SEMAPHORE, 32'h0);
        queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_FULL, 32'hFFFF_FFFF);
        queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_BUSY, 32'hFFFF_FFFF);
        queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_LOCAL_ADDR, 32'hFFFF_FFFF);
        queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_RAM_ADDR, 32'hFFFF_FFFF);
        queue_request(cdma_pkg::CMD_READ, cdma_pkg::REG_LOCAL_ADDR, 32'h0);
        // Two 16-byte rows, maximum skip, both cursors wrap; then queue and overflow
        queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_RD_LEN, 32'hFF80_1008);
        queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_WR_LEN, 32'h0000_0000);
        queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_RD_LEN, 32'hFFFF_FFFF);
        queue_request(cdma_pkg::CMD_READ, cdma_pkg::REG_FULL, 32'h0);
        queue_request(cdma_pkg::CMD_READ, cdma_pkg::REG_BUSY, 32'h0);
        queue_request(cdma_pkg::CMD_READ, cdma_pkg::REG_LOCAL_ADDR, 32'h0);
        repeat (6)
            queue_request(cdma_pkg::CMD_TICK, 3'($urandom_range(0, 7)), $urandom);

        // Random: mostly programmed transfers followed by ticks, plus noise
        while (planned_count < RANDOM_REQS)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
            begin
                if (pick != 0)
                begin
                    queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_LOCAL_ADDR, $urandom);
                    queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_RAM_ADDR, $urandom);
                end
                len_word = ($urandom & 32'hFFF0_0007) | (32'($urandom_range(0, 3)) << 12) |
                           32'($urandom_range(0, 47));
                queue_request(cdma_pkg::CMD_WRITE,
                              $urandom_range(0, 1) ? cdma_pkg::REG_WR_LEN
                                                   : cdma_pkg::REG_RD_LEN,
                              len_word);
                n = $urandom_range(2, 36);
                repeat (n)
                begin
                    if ($urandom_range(0, 4) == 0)
                        queue_request(cdma_pkg::CMD_READ, 3'($urandom_range(0, 7)), $urandom);
                    else
                        queue_request(cdma_pkg::CMD_TICK, 3'($urandom_range(0, 7)), $urandom);
                end
            end
            else if (pick == 6)
                queue_request(cdma_pkg::cmd_t'($urandom_range(0, 2)), 3'($urandom_range(0, 7)),
                              $urandom);
            else if (pick == 7)
            begin
                queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_STATUS, $urandom);
                queue_request(cdma_pkg::CMD_READ, cdma_pkg::REG_STATUS, $urandom);
            end
            else if (pick == 8)
            begin
                queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_SEMAPHORE, $urandom);
                queue_request(cdma_pkg::CMD_READ, cdma_pkg::REG_SEMAPHORE, $urandom);
            end
            else
                repeat (3)
                    queue_request(cdma_pkg::CMD_READ, 3'($urandom_range(0, 7)), $urandom);
        end

        // Largest transfer last: full row and row count, only partly run
        repeat (40)
            queue_request(cdma_pkg::CMD_TICK, 3'($urandom_range(0, 7)), $urandom);
        queue_request(cdma_pkg::CMD_WRITE, cdma_pkg::REG_RD_LEN, 32'hFFFF_FFFF);
        repeat (10)
        begin
            queue_request(cdma_pkg::CMD_TICK, 3'($urandom_range(0, 7)), $urandom);
            queue_request(cdma_pkg::CMD_READ, cdma_pkg::REG_RD_LEN, $urandom);
            queue_request(cdma_pkg::CMD_READ, cdma_pkg::REG_WR_LEN, $urandom);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_queue.size() != 0 || cmd_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
